// ===== rtl/pfr_pkg.sv =====
// ---------------------------------------------------------------------------
// pfr_pkg: shared types and constants for the page frame replacement block
// Frame count, page width, register indexes and the lookup result record.
// ---------------------------------------------------------------------------
package pfr_pkg;

	localparam int FRAMES    = 8;
	localparam int PAGE_BITS = 16;

	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RANK_W = IDX_W;
	localparam int NCNT_W = $clog2(FRAMES + 1);

	// fixed field widths of the stream and register interface
	localparam int FIU_W        = 4;
	localparam int CFG_W        = 4;
	localparam int FRAME_OUT_W  = 3;
	localparam int PAGE_IO_W    = 16;
	localparam int CNT_W        = 32;

	localparam logic REG_FRAMES_IN_USE = 1'b0;
	localparam logic REG_POLICY        = 1'b1;

	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	localparam logic [FIU_W-1:0] FIU_RESET = FIU_W'(8);

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [RANK_W-1:0]    rank_t;
	typedef logic [NCNT_W-1:0]    ncnt_t;

	typedef struct packed {
		logic  hit;
		idx_t  frame;
		logic  ev_valid;
		page_t ev_page;
	} lookup_t;

endpackage

// ===== rtl/page_frame_replacement.sv =====
// ---------------------------------------------------------------------------
// page_frame_replacement: FIFO / LRU page frame replacement engine
// ---------------------------------------------------------------------------
// Each item on the s_ stream is one page reference (page in s_tdata[15:0]).
// Each reference yields exactly one item on the m_ stream: hit flag, frame
// index, evicted page if any and the saturating hit and fault totals.
// The reference is registered on acceptance, then matched against all frames
// in use and written to the output register. One reference per cycle is
// sustained while the output is taken; the frame table updates in the
// same edge that loads the result, so the next reference sees it at once.
// When m_tready is low the output register holds, the input stage holds its
// reference and s_tready drops until the output is taken.
// Registers: index 0 frames_in_use (4 bits, reset 8), index 1 policy
// (0 FIFO, 1 LRU, reset 1). Write them only while the block is idle.
// Reset clears all frames, ranks, FIFO pointer and both totals at once.
// ---------------------------------------------------------------------------
module page_frame_replacement (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] page

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // [2:0] frame, [18:3] evicted_page,
	                               // [50:19] hit_count, [82:51] fault_count
	output logic [1:0]  m_tuser,   // [0] hit, [1] evicted_valid

	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_wdata
);
	import pfr_pkg::*;

	logic [FIU_W-1:0]     fiu_q;
	logic                 policy_q;
	ncnt_t                n_active;

	logic                 valid_s1;
	page_t                page_s1;
	logic                 advance;
	logic                 step;

	lookup_t              res;

	logic                 out_valid_q;
	logic                 hit_q;
	logic                 ev_valid_q;
	logic [FRAME_OUT_W-1:0] frame_q;
	logic [PAGE_IO_W-1:0] ev_page_q;
	logic [CNT_W-1:0]     hits_q;
	logic [CNT_W-1:0]     faults_q;

	always_comb begin
		if (fiu_q == '0)                 n_active = NCNT_W'(1);
		else if (32'(fiu_q) > FRAMES)    n_active = NCNT_W'(FRAMES);
		else                             n_active = NCNT_W'(fiu_q);
	end

	assign advance  = !out_valid_q || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q    <= FIU_RESET;
			policy_q <= POLICY_LRU;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAMES_IN_USE: fiu_q    <= cfg_wdata;
				REG_POLICY:        policy_q <= cfg_wdata[0];
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) page_s1 <= PAGE_BITS'(s_tdata);
	end

	pfr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.page     (page_s1),
		.n_active (n_active),
		.lru      (policy_q == POLICY_LRU),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hits_q      <= '0;
			faults_q    <= '0;
		end else begin
			if (step) begin
				out_valid_q <= 1'b1;
				if (res.hit) begin
					if (hits_q != '1) hits_q <= hits_q + CNT_W'(1);
				end else begin
					if (faults_q != '1) faults_q <= faults_q + CNT_W'(1);
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			hit_q      <= res.hit;
			ev_valid_q <= res.ev_valid;
			frame_q    <= FRAME_OUT_W'(res.frame);
			ev_page_q  <= PAGE_IO_W'(res.ev_page);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {ev_valid_q, hit_q};
	assign m_tdata  = {5'b0, faults_q, hits_q, ev_page_q, frame_q};

endmodule

// ===== rtl/pfr_core.sv =====
// ---------------------------------------------------------------------------
// pfr_core: frame table, match and victim selection
// Holds the resident pages, valid bits, LRU ranks and FIFO pointer; on each
// step it resolves one reference and updates the table at the clock edge.
// ---------------------------------------------------------------------------
module pfr_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  pfr_pkg::page_t  page,
	input  pfr_pkg::ncnt_t  n_active,
	input  logic            lru,
	output pfr_pkg::lookup_t res
);
	import pfr_pkg::*;

	page_t              pages_q [FRAMES];
	logic [FRAMES-1:0]  valid_q;
	rank_t              rank_q  [FRAMES];
	idx_t               fifo_ptr_q;

	logic [FRAMES-1:0]  in_use;
	logic [FRAMES-1:0]  hit_vec;
	logic [FRAMES-1:0]  empty_vec;
	logic               found;
	logic               empty_found;
	idx_t               hit_idx;
	idx_t               empty_idx;
	idx_t               lru_idx;
	rank_t              lru_best;
	idx_t               fifo_idx;
	idx_t               target;
	ncnt_t              target_inc;
	idx_t               fifo_next;
	logic [RANK_W:0]    old_rank;
	logic [FRAMES-1:0]  age_vec;

	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			in_use[i]    = (NCNT_W'(i) < n_active);
			hit_vec[i]   = in_use[i] && valid_q[i] && (pages_q[i] == page);
			empty_vec[i] = in_use[i] && !valid_q[i];
		end

		found   = |hit_vec;
		hit_idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (hit_vec[i]) hit_idx = IDX_W'(i);
		end

		empty_found = |empty_vec;
		empty_idx   = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (empty_vec[i]) empty_idx = IDX_W'(i);
		end

		// oldest frame, lowest index wins a tie
		lru_idx  = '0;
		lru_best = rank_q[0];
		for (int i = 1; i < FRAMES; i++) begin
			if (in_use[i] && rank_q[i] > lru_best) begin
				lru_best = rank_q[i];
				lru_idx  = IDX_W'(i);
			end
		end

		fifo_idx = (NCNT_W'(fifo_ptr_q) < n_active) ? fifo_ptr_q : '0;

		if (found)            target = hit_idx;
		else if (empty_found) target = empty_idx;
		else if (lru)         target = lru_idx;
		else                  target = fifo_idx;

		target_inc = NCNT_W'(target) + NCNT_W'(1);
		fifo_next  = (target_inc >= n_active) ? '0 : IDX_W'(target_inc);

		// a fill ages every other valid in-use frame below the top rank; a hit ages only younger ones
		old_rank = found ? {1'b0, rank_q[target]} : (RANK_W+1)'(FRAMES);
		for (int i = 0; i < FRAMES; i++) begin
			age_vec[i] = (IDX_W'(i) != target) && valid_q[i] && in_use[i] &&
				({1'b0, rank_q[i]} < old_rank) && (rank_q[i] != RANK_W'(FRAMES - 1));
		end

		res.hit      = found;
		res.frame    = target;
		res.ev_valid = !found && !empty_found;
		res.ev_page  = (!found && !empty_found) ? pages_q[target] : '0;
	end

	always_ff @(posedge clk) begin
		if (step && !found) pages_q[target] <= page;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			fifo_ptr_q <= '0;
			for (int i = 0; i < FRAMES; i++) rank_q[i] <= '0;
		end else if (step) begin
			if (!found) valid_q[target] <= 1'b1;
			if (lru) begin
				for (int i = 0; i < FRAMES; i++) begin
					if (age_vec[i]) rank_q[i] <= rank_q[i] + RANK_W'(1);
				end
				rank_q[target] <= '0;
			end else if (!found) begin
				fifo_ptr_q <= fifo_next;
			end
		end
	end

	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((valid_q & $past(valid_q)) == $past(valid_q)))
		else $error("frame valid bit dropped");

	a_target_valid: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_q[$past(target)])
		else $error("target frame not valid after step");

	a_lru_mru: assert property (@(posedge clk) disable iff (!arst_n)
		(step && lru) |=> (rank_q[$past(target)] == '0))
		else $error("referenced frame not most recent");

endmodule
